// ===== rtl/irlmc_pkg.sv =====
// Shared types and constants for the IR remote light-mode controller.
// Holds the remote key codes, register indexes, mode and op types and the colour decode.
// No dependencies; every other file imports this package.
`default_nettype none

package irlmc_pkg;

    // Width of the tick period registers and phase counters.
    localparam int unsigned TICK_W = 16;

    typedef enum logic {
        OP_FRAME = 1'b0,
        OP_TICK  = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        MODE_SOLID      = 2'd0,
        MODE_STEPPED    = 2'd1,
        MODE_CONTINUOUS = 2'd2
    } t_mode;

    typedef enum logic [2:0] {
        REG_MIN_BRIGHT   = 3'd0,
        REG_MAX_BRIGHT   = 3'd1,
        REG_BRIGHT_STEP  = 3'd2,
        REG_COLOUR_TICKS = 3'd3,
        REG_BAND_TICKS   = 3'd4,
        REG_BLINK_TICKS  = 3'd5
    } t_reg_idx;

    // Remote key codes.
    localparam logic [7:0] KEY_POWER_ON   = 8'h45;
    localparam logic [7:0] KEY_DIM_WHITE  = 8'h46;
    localparam logic [7:0] KEY_POWER_OFF  = 8'h47;
    localparam logic [7:0] KEY_STEPPED    = 8'h44;
    localparam logic [7:0] KEY_CONTINUOUS = 8'h07;
    localparam logic [7:0] KEY_BRIGHT_UP  = 8'h15;
    localparam logic [7:0] KEY_BRIGHT_DN  = 8'h09;
    localparam logic [7:0] KEY_FULL_WHITE = 8'h4a;
    localparam logic [7:0] KEY_RED        = 8'h16;
    localparam logic [7:0] KEY_GREEN      = 8'h19;
    localparam logic [7:0] KEY_BLUE       = 8'h0d;
    localparam logic [7:0] KEY_ORANGE     = 8'h0c;
    localparam logic [7:0] KEY_LT_GREEN   = 8'h18;
    localparam logic [7:0] KEY_LT_BLUE    = 8'h5e;
    localparam logic [7:0] KEY_INDIGO     = 8'h08;
    localparam logic [7:0] KEY_LT_ORANGE  = 8'h1c;
    localparam logic [7:0] KEY_LTST_BLUE  = 8'h5a;
    localparam logic [7:0] KEY_VIOLET     = 8'h42;
    localparam logic [7:0] KEY_YELLOW     = 8'h52;

    // Colour codes: named colours first, then the wheel entries.
    localparam logic [4:0] COLOUR_WHITE      = 5'd0;
    localparam logic [4:0] COLOUR_WHEEL_BASE = 5'd12;

    localparam logic [6:0] RST_MIN_BRIGHT   = 7'd5;
    localparam logic [6:0] RST_MAX_BRIGHT   = 7'd100;
    localparam logic [6:0] RST_BRIGHT_STEP  = 7'd5;
    localparam logic [6:0] RST_BRIGHTNESS   = 7'd25;
    localparam logic [15:0] RST_COLOUR_TICKS = 16'd10;
    localparam logic [15:0] RST_BAND_TICKS   = 16'd10;
    localparam logic [15:0] RST_BLINK_TICKS  = 16'd50;

    typedef struct packed {
        logic       hit;
        logic [4:0] code;
    } t_colour_hit;

    // Maps a named-colour key to its colour code.
    function automatic t_colour_hit f_named_colour(input logic [7:0] key);
        t_colour_hit r;
        r.hit  = 1'b1;
        r.code = COLOUR_WHITE;
        unique case (key)
            KEY_RED:       r.code = 5'd1;
            KEY_GREEN:     r.code = 5'd2;
            KEY_BLUE:      r.code = 5'd3;
            KEY_ORANGE:    r.code = 5'd4;
            KEY_LT_GREEN:  r.code = 5'd5;
            KEY_LT_BLUE:   r.code = 5'd6;
            KEY_INDIGO:    r.code = 5'd7;
            KEY_LT_ORANGE: r.code = 5'd8;
            KEY_LTST_BLUE: r.code = 5'd9;
            KEY_VIOLET:    r.code = 5'd10;
            KEY_YELLOW:    r.code = 5'd11;
            default:       r.hit  = 1'b0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/irlmc_phase.sv =====
// Tick phase counter for one periodic event of the light-mode controller.
// Fires when the phase is zero and advances it on each tick; depends on irlmc_pkg.
`default_nettype none

module irlmc_phase (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_step,
    input  wire logic [irlmc_pkg::TICK_W-1:0] i_period,
    output logic                             o_fire
);
    import irlmc_pkg::*;

    logic [TICK_W-1:0] r_phase;
    logic [TICK_W-1:0] n_phase;
    logic [TICK_W-1:0] w_period;
    logic [TICK_W:0]   w_next;

    // A period of zero behaves as one; a phase left above a shrunk period wraps.
    assign w_period = (i_period == '0) ? TICK_W'(1) : i_period;
    assign w_next   = {1'b0, r_phase} + (TICK_W + 1)'(1);
    assign o_fire   = (r_phase == '0);

    always_comb begin
        n_phase = r_phase;
        if (i_step) begin
            n_phase = (w_next >= {1'b0, w_period}) ? '0 : w_next[TICK_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
        end else begin
            r_phase <= n_phase;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/ir_remote_light_mode_controller_top.sv =====
// Top level of the IR remote light-mode controller: input register, command logic,
// configuration registers and the result handshake. Depends on irlmc_pkg and irlmc_phase.
//
// Usage: each input word on the s_axis channel is either a received 32-bit NEC frame
// (tuser = 0) or one time tick (tuser = 1). Every word gives exactly one result word
// on the m_axis channel carrying the light state after that word and a frame_ok flag.
// Configuration goes through the APB port (six registers at byte addresses 0 to 20)
// and must be written only while no word is in flight; the block does not enforce this.
// A word accepted into the input register is processed once the result register is free or
// being taken; its result is then registered and offered on m_axis until it is taken.
// One word per cycle unless m_axis stalls; the command logic is a single registered stage.
// The input register takes a new word while a finished result waits to be taken.
// When the receiver stalls, the result holds and one further word waits in the input
// register; s_axis_tready then falls until the result is taken.
// Reset (synchronous, active low) returns the light to on, solid white, brightness 25,
// the status LED high and all registers to their defaults. No clearing pass is needed.
`default_nettype none

module ir_remote_light_mode_controller_top #(
    parameter int unsigned WHEEL_SIZE = 6,
    parameter int unsigned BAND_COUNT = 7
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Input word
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,   // [31:0] raw_frame
    input  wire logic [0:0]  s_axis_tuser,   // [0] op
    // Result word
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [0] lit, [2:1] colour_mode, [9:3] brightness, [14:10] colour_code,
    // [17:15] band_offset, [18] status_led, [23:19] zero
    output logic [23:0]      m_axis_tdata,
    output logic [0:0]       m_axis_tuser,   // [0] frame_ok
    // Configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import irlmc_pkg::*;

    localparam int unsigned WHEEL_W = (WHEEL_SIZE > 1) ? $clog2(WHEEL_SIZE) : 1;
    localparam int unsigned BAND_W  = (BAND_COUNT > 1) ? $clog2(BAND_COUNT) : 1;

    // Configuration registers
    logic [6:0]        r_min_bright, r_max_bright, r_bright_step;
    logic [TICK_W-1:0] r_colour_ticks, r_band_ticks, r_blink_ticks;
    logic              w_cfg_wr;
    t_reg_idx          w_cfg_idx;

    // Input register
    logic              r_in_valid;
    t_op               r_in_op;
    logic [31:0]       r_in_frame;
    logic              w_proc;

    // Light state; it doubles as the result payload, since it only changes
    // when the previous result has been taken.
    logic              r_lit, n_lit;
    t_mode             r_mode, n_mode;
    logic [6:0]        r_bright, n_bright;
    logic [4:0]        r_colour, n_colour;
    logic [7:0]        r_last, n_last;
    logic [7:0]        r_held, n_held;
    logic [WHEEL_W-1:0] r_wheel, n_wheel, w_wheel_inc;
    logic [BAND_W-1:0] r_band, n_band, w_band_inc;
    logic              r_led, n_led;
    logic              r_ok, n_ok;
    logic              r_out_valid;
    logic [BAND_W+2:0] w_band_ext;

    // Decode
    logic [7:0]        w_addr, w_addr_n, w_code, w_code_n;
    logic              w_frame_valid;
    logic [7:0]        w_up_sum;
    logic              w_up_ok, w_dn_ok;
    logic [6:0]        w_dn_val;
    t_colour_hit       w_named;
    logic              w_tick;
    logic              w_blink_fire, w_colour_fire, w_band_fire;

    // ---------------- Configuration port ----------------
    assign pready    = 1'b1;
    assign w_cfg_wr  = psel && penable && pwrite && pready;
    assign w_cfg_idx = t_reg_idx'(paddr[4:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_bright   <= RST_MIN_BRIGHT;
            r_max_bright   <= RST_MAX_BRIGHT;
            r_bright_step  <= RST_BRIGHT_STEP;
            r_colour_ticks <= RST_COLOUR_TICKS;
            r_band_ticks   <= RST_BAND_TICKS;
            r_blink_ticks  <= RST_BLINK_TICKS;
        end else if (w_cfg_wr) begin
            unique case (w_cfg_idx)
                REG_MIN_BRIGHT:   r_min_bright   <= pwdata[6:0];
                REG_MAX_BRIGHT:   r_max_bright   <= pwdata[6:0];
                REG_BRIGHT_STEP:  r_bright_step  <= pwdata[6:0];
                REG_COLOUR_TICKS: r_colour_ticks <= pwdata[TICK_W-1:0];
                REG_BAND_TICKS:   r_band_ticks   <= pwdata[TICK_W-1:0];
                REG_BLINK_TICKS:  r_blink_ticks  <= pwdata[TICK_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_cfg_idx)
            REG_MIN_BRIGHT:   prdata = {25'd0, r_min_bright};
            REG_MAX_BRIGHT:   prdata = {25'd0, r_max_bright};
            REG_BRIGHT_STEP:  prdata = {25'd0, r_bright_step};
            REG_COLOUR_TICKS: prdata = {16'd0, r_colour_ticks};
            REG_BAND_TICKS:   prdata = {16'd0, r_band_ticks};
            REG_BLINK_TICKS:  prdata = {16'd0, r_blink_ticks};
            default:          prdata = '0;
        endcase
    end

    // ---------------- Handshake ----------------
    assign w_proc        = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_proc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (w_proc) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_op    <= t_op'(s_axis_tuser[0]);
            r_in_frame <= s_axis_tdata;
        end
    end

    // ---------------- Tick phases ----------------
    assign w_tick = w_proc && (r_in_op == OP_TICK);

    irlmc_phase u_blink_phase (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_tick),
        .i_period (r_blink_ticks),
        .o_fire   (w_blink_fire)
    );

    irlmc_phase u_colour_phase (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_tick),
        .i_period (r_colour_ticks),
        .o_fire   (w_colour_fire)
    );

    irlmc_phase u_band_phase (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_tick),
        .i_period (r_band_ticks),
        .o_fire   (w_band_fire)
    );

    // ---------------- Frame decode and command logic ----------------
    assign w_addr        = r_in_frame[7:0];
    assign w_addr_n      = r_in_frame[15:8];
    assign w_code        = r_in_frame[23:16];
    assign w_code_n      = r_in_frame[31:24];
    assign w_frame_valid = (w_addr == ~w_addr_n) && (w_code == ~w_code_n);
    assign w_named       = f_named_colour(w_code);

    // Brightness moves only by a whole step that stays within the limits.
    assign w_up_sum = {1'b0, r_bright} + {1'b0, r_bright_step};
    assign w_up_ok  = (w_up_sum <= {1'b0, r_max_bright});
    assign w_dn_val = r_bright - r_bright_step;
    assign w_dn_ok  = (r_bright >= r_bright_step) && (w_dn_val >= r_min_bright);

    assign w_wheel_inc = (r_wheel == WHEEL_W'(WHEEL_SIZE - 1)) ? '0 : r_wheel + WHEEL_W'(1);
    assign w_band_inc  = (r_band == BAND_W'(BAND_COUNT - 1)) ? '0 : r_band + BAND_W'(1);

    always_comb begin
        n_lit    = r_lit;
        n_mode   = r_mode;
        n_bright = r_bright;
        n_colour = r_colour;
        n_last   = r_last;
        n_held   = r_held;
        n_wheel  = r_wheel;
        n_band   = r_band;
        n_led    = r_led;
        n_ok     = r_ok;
        if (w_proc) begin
            n_ok = 1'b0;
            if (r_in_op == OP_FRAME) begin
                if (w_frame_valid) begin
                    n_ok   = 1'b1;
                    n_held = w_code;
                    n_last = w_code;
                    if (w_code != r_last) begin
                        if (r_lit) begin
                            unique case (w_code)
                                KEY_DIM_WHITE: begin
                                    n_mode   = MODE_SOLID;
                                    n_colour = COLOUR_WHITE;
                                    n_bright = r_min_bright;
                                end
                                KEY_FULL_WHITE: begin
                                    n_mode   = MODE_SOLID;
                                    n_colour = COLOUR_WHITE;
                                    n_bright = r_max_bright;
                                end
                                KEY_POWER_OFF:  n_lit  = 1'b0;
                                KEY_STEPPED:    n_mode = MODE_STEPPED;
                                KEY_CONTINUOUS: n_mode = MODE_CONTINUOUS;
                                KEY_BRIGHT_UP: begin
                                    if (w_up_ok) begin
                                        n_bright = w_up_sum[6:0];
                                    end
                                end
                                KEY_BRIGHT_DN: begin
                                    if (w_dn_ok) begin
                                        n_bright = w_dn_val;
                                    end
                                end
                                default: begin
                                    if (w_named.hit) begin
                                        n_mode   = MODE_SOLID;
                                        n_colour = w_named.code;
                                    end
                                end
                            endcase
                        end else if (w_code == KEY_POWER_ON) begin
                            n_lit = 1'b1;
                        end
                    end
                end else if (r_lit) begin
                    // A corrupt frame is taken as a held key: repeat the last step.
                    if (r_held == KEY_BRIGHT_UP && w_up_ok) begin
                        n_bright = w_up_sum[6:0];
                    end else if (r_held == KEY_BRIGHT_DN && w_dn_ok) begin
                        n_bright = w_dn_val;
                    end
                end
            end else begin
                if (w_blink_fire) begin
                    n_led = !r_led;
                end
                if (r_mode == MODE_STEPPED && w_colour_fire) begin
                    n_wheel  = w_wheel_inc;
                    n_colour = COLOUR_WHEEL_BASE + 5'(w_wheel_inc);
                end else if (r_mode == MODE_CONTINUOUS && w_band_fire) begin
                    n_band = w_band_inc;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lit    <= 1'b1;
            r_mode   <= MODE_SOLID;
            r_bright <= RST_BRIGHTNESS;
            r_colour <= COLOUR_WHITE;
            r_last   <= '0;
            r_held   <= '0;
            r_wheel  <= '0;
            r_band   <= '0;
            r_led    <= 1'b1;
            r_ok     <= 1'b0;
        end else begin
            r_lit    <= n_lit;
            r_mode   <= n_mode;
            r_bright <= n_bright;
            r_colour <= n_colour;
            r_last   <= n_last;
            r_held   <= n_held;
            r_wheel  <= n_wheel;
            r_band   <= n_band;
            r_led    <= n_led;
            r_ok     <= n_ok;
        end
    end

    // ---------------- Result word ----------------
    assign w_band_ext    = {3'b000, r_band};
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'd0, r_led, w_band_ext[2:0], r_colour, r_bright, r_mode, r_lit};
    assign m_axis_tuser  = r_ok;

    // ---------------- Assertions ----------------
    // The light only comes back on through a valid power-on frame.
    a_power_on_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && !$past(r_lit) && r_lit |->
            $past(w_proc && r_in_op == OP_FRAME && w_frame_valid && w_code == KEY_POWER_ON))
        else $error("light turned on without a valid power-on frame");

    // No state moves unless a word is being processed.
    a_state_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && !$past(w_proc) |->
            $stable({r_lit, r_mode, r_bright, r_colour, r_last, r_held,
                     r_wheel, r_band, r_led, r_ok}))
        else $error("light state changed without a processed word");

    // A tick never reports a decoded frame.
    a_tick_not_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $past(w_proc && r_in_op == OP_TICK) |-> !r_ok)
        else $error("tick reported as a valid frame");

    // Wheel and band indexes stay within their ranges.
    a_index_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (32'(r_wheel) < WHEEL_SIZE) && (32'(r_band) < BAND_COUNT))
        else $error("wheel or band index out of range");

    // A result is only offered for a word that was held in the input register.
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && !$past(r_out_valid) && r_out_valid |-> $past(r_in_valid))
        else $error("result appeared without an input word");

endmodule

`default_nettype wire
